>>> design/gbi_pkg.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator package
// Shared widths, default parameter values, item opcodes and register indexes.
// ----------------------------------------------------------------------------
package gbi_pkg;

  // Fixed field widths of the item channels and the register port.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PADDR_W = 5;

  // Default values for the top-level parameters.
  localparam int unsigned MAX_X_POINTS_DEF = 64;
  localparam int unsigned MAX_Y_POINTS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  // Operation carried by one input item.
  typedef enum logic [OP_W-1:0] {
    OP_WR_X  = 2'd0,
    OP_WR_Y  = 2'd1,
    OP_WR_Z  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  // Register index, taken from paddr above the byte offset.
  typedef enum logic [PADDR_W-3:0] {
    REG_X_COUNT   = 3'd0,
    REG_Y_COUNT   = 3'd1,
    REG_X_UNIFORM = 3'd2,
    REG_Y_UNIFORM = 3'd3,
    REG_OUTSIDE   = 3'd4
  } reg_e;

endpackage

>>> design/gbi_in_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries table writes and query points.
// ----------------------------------------------------------------------------
interface gbi_in_if;
  logic                              valid;
  logic                              ready;
  logic [gbi_pkg::OP_W-1:0]          opcode;
  logic [gbi_pkg::IDX_W-1:0]         row_index;
  logic [gbi_pkg::IDX_W-1:0]         col_index;
  logic signed [gbi_pkg::DATA_W-1:0] entry_value;
  logic signed [gbi_pkg::DATA_W-1:0] query_x;
  logic signed [gbi_pkg::DATA_W-1:0] query_y;

  modport source (
    output valid, opcode, row_index, col_index, entry_value, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, row_index, col_index, entry_value, query_x, query_y,
    output ready
  );
endinterface

>>> design/gbi_out_if.sv
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel that carries one interpolated value per query.
// ----------------------------------------------------------------------------
interface gbi_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gbi_pkg::DATA_W-1:0] result_value;
  logic                              was_outside;

  modport source (
    output valid, result_value, was_outside,
    input  ready
  );
  modport sink (
    input  valid, result_value, was_outside,
    output ready
  );
endinterface

>>> design/grid_bilinear_interpolator.sv
// ----------------------------------------------------------------------------
// Grid bilinear interpolator
// Holds an x axis, a y axis and a z grid and answers bilinear queries.
// ----------------------------------------------------------------------------
// Usage: items enter on in_i. A write item (x point, y point, grid value)
// is stored at the cycle it is accepted and produces no result; write items
// can follow each other at one per cycle while no query is in work. A query
// item produces exactly one result item on out_o: the interpolated Q16.16
// value, or the configured outside value with was_outside set.
// The user must keep to this: registers are written over the APB port while
// the block is idle; the block itself does not enforce it. A query first
// reads the end points of both axes and checks the range; a point outside
// the axes gets the outside value. Inside, each axis is located directly on
// an end point, otherwise by one divider run on a uniform axis, or on any
// other axis by a bisection search, a read of the two cell points and a
// divider run; then the grid corners are read and blended. The query time is
// set by the one-bit-per-cycle divider and the single read port of the axis
// memory. One query is in work at a time.
// Reset clears the registers to x_count 2, y_count 2, both uniform flags off
// and outside value 0; the axis and grid memories are not cleared.
// A stalled receiver holds the result in the output register; the block
// still accepts write items meanwhile, and a finished query waits for it.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator #(
  parameter int unsigned MAX_X_POINTS = gbi_pkg::MAX_X_POINTS_DEF,
  parameter int unsigned MAX_Y_POINTS = gbi_pkg::MAX_Y_POINTS_DEF,
  parameter int unsigned FRAC_BITS    = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gbi_in_if.sink                       in_i,
  gbi_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbi_pkg::PADDR_W-1:0]  paddr,
  input  logic [gbi_pkg::DATA_W-1:0]   pwdata,
  output logic [gbi_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import gbi_pkg::*;

  localparam int unsigned NW_X   = $clog2(MAX_X_POINTS + 1);
  localparam int unsigned NW_Y   = $clog2(MAX_Y_POINTS + 1);
  localparam int unsigned NW_XY  = (NW_X > NW_Y) ? NW_X : NW_Y;
  localparam int unsigned NW     = (NW_XY > CNT_W) ? NW_XY : CNT_W;
  localparam int unsigned AX_DEP = MAX_X_POINTS + MAX_Y_POINTS;
  localparam int unsigned AX_AW  = $clog2(AX_DEP);
  localparam int unsigned GR_DEP = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int unsigned GR_AW  = $clog2(GR_DEP);
  localparam int unsigned QW     = DATA_W + 1;
  localparam int unsigned DIV_DW = DATA_W + NW + FRAC_BITS;
  localparam int unsigned WT_W   = FRAC_BITS + 1;
  localparam int unsigned PR_W   = DATA_W + WT_W + 1;
  localparam int unsigned ACC_W  = DATA_W + FRAC_BITS + 3;

  localparam logic [WT_W-1:0]  W_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENDS  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_LOC   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_BIS   = 4'd5;
  localparam logic [3:0] S_BCMP  = 4'd6;
  localparam logic [3:0] S_NB0   = 4'd7;
  localparam logic [3:0] S_NB1   = 4'd8;
  localparam logic [3:0] S_NB2   = 4'd9;
  localparam logic [3:0] S_DIVW  = 4'd10;
  localparam logic [3:0] S_LDONE = 4'd11;
  localparam logic [3:0] S_GRID  = 4'd12;
  localparam logic [3:0] S_BLEND = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  // Configuration registers.
  logic [CNT_W-1:0]         xcnt_q, ycnt_q;
  logic                     xuni_q, yuni_q;
  logic signed [DATA_W-1:0] outv_q;
  logic                     cfg_we;
  reg_e                     cfg_idx;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xcnt_q <= CNT_W'(2);
      ycnt_q <= CNT_W'(2);
      xuni_q <= 1'b0;
      yuni_q <= 1'b0;
      outv_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_COUNT:   xcnt_q <= pwdata[CNT_W-1:0];
        REG_Y_COUNT:   ycnt_q <= pwdata[CNT_W-1:0];
        REG_X_UNIFORM: xuni_q <= pwdata[0];
        REG_Y_UNIFORM: yuni_q <= pwdata[0];
        REG_OUTSIDE:   outv_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_X_COUNT:   prdata = DATA_W'(xcnt_q);
      REG_Y_COUNT:   prdata = DATA_W'(ycnt_q);
      REG_X_UNIFORM: prdata = DATA_W'(xuni_q);
      REG_Y_UNIFORM: prdata = DATA_W'(yuni_q);
      REG_OUTSIDE:   prdata = outv_q;
      default:       prdata = '0;
    endcase
  end

  // Point counts clamped to the supported range.
  logic [NW-1:0] cx, cy, nx, ny;
  assign cx = NW'(xcnt_q);
  assign cy = NW'(ycnt_q);
  assign nx = (cx < NW'(2)) ? NW'(2) : ((cx > NW'(MAX_X_POINTS)) ? NW'(MAX_X_POINTS) : cx);
  assign ny = (cy < NW'(2)) ? NW'(2) : ((cy > NW'(MAX_Y_POINTS)) ? NW'(MAX_Y_POINTS) : cy);

  // Sequencer and datapath registers.
  logic [3:0]               st_q;
  logic [2:0]               cnt_q;
  logic                     ax_q;
  logic                     uni_q;
  logic signed [DATA_W-1:0] qx_q, qy_q;
  logic signed [DATA_W-1:0] ends_q [4];
  logic [NW-1:0]            lo_q, hi_q, mid_q;
  logic signed [DATA_W-1:0] xlo_q;
  logic [NW-1:0]            idx_q, ix_q, iy_q;
  logic [WT_W-1:0]          wt_q, ux_q, uy_q;
  logic [DATA_W+NW-1:0]     prod_q;
  logic signed [DATA_W-1:0] z_q [4];
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W-1:0] a_q, b_q, res_q;
  logic                     outside_q;
  logic                     ovalid_q;
  logic signed [DATA_W-1:0] ores_q;
  logic                     oout_q;

  // Memories: both axes share one store, y entries after the x entries.
  logic signed [DATA_W-1:0] ax_mem [AX_DEP];
  logic signed [DATA_W-1:0] gr_mem [GR_DEP];
  logic signed [DATA_W-1:0] ax_rdata_q, gr_rdata_q;
  logic                     ax_we, gr_we, in_fire;
  logic [AX_AW-1:0]         ax_waddr, ax_raddr, ax_base;
  logic [GR_AW-1:0]         gr_waddr, gr_raddr, gr_r0;
  op_e                      in_op;

  assign in_i.ready = (st_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_op      = op_e'(in_i.opcode);

  // Write decode for table items.
  always_comb begin
    ax_we    = 1'b0;
    gr_we    = 1'b0;
    ax_waddr = AX_AW'(in_i.row_index);
    gr_waddr = GR_AW'(32'(in_i.row_index) * 32'(MAX_Y_POINTS) + 32'(in_i.col_index));
    unique case (in_op)
      OP_WR_X: ax_we = in_fire && (32'(in_i.row_index) < MAX_X_POINTS);
      OP_WR_Y: begin
        ax_we    = in_fire && (32'(in_i.col_index) < MAX_Y_POINTS);
        ax_waddr = AX_AW'(MAX_X_POINTS) + AX_AW'(in_i.col_index);
      end
      OP_WR_Z: gr_we = in_fire && (32'(in_i.row_index) < MAX_X_POINTS) &&
                       (32'(in_i.col_index) < MAX_Y_POINTS);
      OP_QUERY: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ax_we) begin
      ax_mem[ax_waddr] <= in_i.entry_value;
    end
    ax_rdata_q <= ax_mem[ax_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (gr_we) begin
      gr_mem[gr_waddr] <= in_i.entry_value;
    end
    gr_rdata_q <= gr_mem[gr_raddr];
  end

  // Values of the axis currently being located.
  logic signed [DATA_W-1:0] cur_q, cur_first, cur_last;
  logic [NW-1:0]            cur_n, nm1, nm2;
  logic                     cur_uni;
  logic signed [QW-1:0]     d_w, s_w, num_w, den_w;
  logic                     nb_ok;
  logic [NW:0]              bsum;
  logic [NW-1:0]            mid_w;
  logic                     bis_more;

  assign cur_q     = ax_q ? qy_q : qx_q;
  assign cur_first = ax_q ? ends_q[2] : ends_q[0];
  assign cur_last  = ax_q ? ends_q[3] : ends_q[1];
  assign cur_n     = ax_q ? ny : nx;
  assign cur_uni   = ax_q ? yuni_q : xuni_q;
  assign nm1       = cur_n - NW'(1);
  assign nm2       = cur_n - NW'(2);
  assign d_w       = QW'(cur_q) - QW'(cur_first);
  assign s_w       = QW'(cur_last) - QW'(cur_first);
  assign num_w     = QW'(cur_q) - QW'(xlo_q);
  assign den_w     = QW'(ax_rdata_q) - QW'(xlo_q);
  assign nb_ok     = (num_w > 0) && (den_w > 0);
  assign bsum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w     = bsum[NW:1];
  assign bis_more  = ({1'b0, hi_q} > ({1'b0, lo_q} + (NW+1)'(1)));
  assign ax_base   = ax_q ? AX_AW'(MAX_X_POINTS) : '0;

  // Axis memory read address.
  always_comb begin
    ax_raddr = '0;
    unique case (st_q)
      S_ENDS: begin
        unique case (cnt_q)
          3'd0:    ax_raddr = '0;
          3'd1:    ax_raddr = AX_AW'(nx - NW'(1));
          3'd2:    ax_raddr = AX_AW'(MAX_X_POINTS);
          default: ax_raddr = AX_AW'(MAX_X_POINTS) + AX_AW'(ny - NW'(1));
        endcase
      end
      S_BIS:   ax_raddr = ax_base + AX_AW'(mid_w);
      S_NB0:   ax_raddr = ax_base + AX_AW'(lo_q);
      S_NB1:   ax_raddr = ax_base + AX_AW'(lo_q) + AX_AW'(1);
      default: ax_raddr = '0;
    endcase
  end

  // Grid read address: the four corners of the located cell.
  assign gr_r0 = GR_AW'(32'(ix_q) * 32'(MAX_Y_POINTS) + 32'(iy_q));

  always_comb begin
    unique case (cnt_q)
      3'd0:    gr_raddr = gr_r0;
      3'd1:    gr_raddr = gr_r0 + GR_AW'(1);
      3'd2:    gr_raddr = gr_r0 + GR_AW'(MAX_Y_POINTS);
      default: gr_raddr = gr_r0 + GR_AW'(MAX_Y_POINTS) + GR_AW'(1);
    endcase
  end

  // Shared divider for the cell weight.
  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_num, div_quo, div_hi;
  logic [DATA_W-1:0] div_den;

  assign div_start = (st_q == S_MUL) || ((st_q == S_NB2) && nb_ok);
  assign div_num   = (st_q == S_MUL) ? {prod_q, {FRAC_BITS{1'b0}}} :
                     DIV_DW'({num_w[DATA_W-1:0], {FRAC_BITS{1'b0}}});
  assign div_den   = (st_q == S_MUL) ? s_w[DATA_W-1:0] : den_w[DATA_W-1:0];
  assign div_hi    = div_quo >> FRAC_BITS;

  gbi_div #(
    .DW (DIV_DW),
    .VW (DATA_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // Blend multiplier: one grid or row value times one weight per cycle.
  logic signed [DATA_W-1:0] mul_z;
  logic [WT_W-1:0]          mul_w;
  logic signed [PR_W-1:0]   prod;
  logic signed [ACC_W-1:0]  acc_rb;
  logic signed [DATA_W-1:0] rnd;
  logic [2:0]               cm1;

  always_comb begin
    unique case (cnt_q)
      3'd0:    begin mul_z = z_q[0]; mul_w = W_ONE - uy_q; end
      3'd1:    begin mul_z = z_q[1]; mul_w = uy_q;         end
      3'd2:    begin mul_z = z_q[2]; mul_w = W_ONE - uy_q; end
      3'd3:    begin mul_z = z_q[3]; mul_w = uy_q;         end
      3'd4:    begin mul_z = a_q;    mul_w = W_ONE - ux_q; end
      default: begin mul_z = b_q;    mul_w = ux_q;         end
    endcase
  end

  assign prod   = mul_z * $signed({1'b0, mul_w});
  assign acc_rb = acc_q + $signed(RND_HALF);
  assign rnd    = acc_rb[FRAC_BITS +: DATA_W];
  assign cm1    = cnt_q - 3'd1;

  // Query sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      cnt_q     <= '0;
      ax_q      <= 1'b0;
      uni_q     <= 1'b0;
      qx_q      <= '0;
      qy_q      <= '0;
      for (int i = 0; i < 4; i++) begin
        ends_q[i] <= '0;
        z_q[i]    <= '0;
      end
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      xlo_q     <= '0;
      idx_q     <= '0;
      wt_q      <= '0;
      ix_q      <= '0;
      iy_q      <= '0;
      ux_q      <= '0;
      uy_q      <= '0;
      prod_q    <= '0;
      acc_q     <= '0;
      a_q       <= '0;
      b_q       <= '0;
      res_q     <= '0;
      outside_q <= 1'b0;
      ovalid_q  <= 1'b0;
      ores_q    <= '0;
      oout_q    <= 1'b0;
    end else begin
      // The output register is refilled in the final state itself.
      if (out_o.ready && (st_q != S_FIN)) begin
        ovalid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_fire && (in_op == OP_QUERY)) begin
            qx_q  <= in_i.query_x;
            qy_q  <= in_i.query_y;
            cnt_q <= '0;
            st_q  <= S_ENDS;
          end
        end
        // Fetch the first and last point of both axes.
        S_ENDS: begin
          if (cnt_q != 3'd0) begin
            ends_q[cm1[1:0]] <= ax_rdata_q;
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            st_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((qx_q < ends_q[0]) || (qx_q > ends_q[1]) ||
              (qy_q < ends_q[2]) || (qy_q > ends_q[3])) begin
            res_q     <= outv_q;
            outside_q <= 1'b1;
            st_q      <= S_FIN;
          end else begin
            outside_q <= 1'b0;
            ax_q      <= 1'b0;
            st_q      <= S_LOC;
          end
        end
        // Start locating the cell on the current axis.
        S_LOC: begin
          if (cur_q == cur_first) begin
            idx_q <= '0;
            wt_q  <= '0;
            st_q  <= S_LDONE;
          end else if (cur_q == cur_last) begin
            idx_q <= nm2;
            wt_q  <= W_ONE;
            st_q  <= S_LDONE;
          end else if (cur_uni) begin
            uni_q <= 1'b1;
            if ((d_w <= 0) || (s_w <= 0)) begin
              idx_q <= '0;
              wt_q  <= '0;
              st_q  <= S_LDONE;
            end else begin
              prod_q <= d_w[DATA_W-1:0] * nm1;
              st_q   <= S_MUL;
            end
          end else begin
            uni_q <= 1'b0;
            lo_q  <= '0;
            hi_q  <= cur_n;
            st_q  <= S_BIS;
          end
        end
        S_MUL: st_q <= S_DIVW;
        // Bisection: the read of the midpoint is issued here.
        S_BIS: begin
          if (bis_more) begin
            mid_q <= mid_w;
            st_q  <= S_BCMP;
          end else begin
            st_q <= S_NB0;
          end
        end
        S_BCMP: begin
          if (ax_rdata_q > cur_q) begin
            hi_q <= mid_q;
          end else begin
            lo_q <= mid_q;
          end
          st_q <= S_BIS;
        end
        // Fetch both points of the found cell.
        S_NB0: begin
          if (lo_q > nm2) begin
            idx_q <= nm2;
            wt_q  <= W_ONE;
            st_q  <= S_LDONE;
          end else begin
            st_q <= S_NB1;
          end
        end
        S_NB1: begin
          xlo_q <= ax_rdata_q;
          st_q  <= S_NB2;
        end
        S_NB2: begin
          idx_q <= lo_q;
          if (nb_ok) begin
            st_q <= S_DIVW;
          end else begin
            wt_q <= '0;
            st_q <= S_LDONE;
          end
        end
        // Turn the quotient into index and weight.
        S_DIVW: begin
          if (div_done) begin
            if (uni_q) begin
              if (div_hi > DIV_DW'(nm2)) begin
                idx_q <= nm2;
                wt_q  <= W_ONE;
              end else begin
                idx_q <= div_hi[NW-1:0];
                wt_q  <= {1'b0, div_quo[FRAC_BITS-1:0]};
              end
            end else begin
              wt_q <= (div_quo > DIV_DW'(W_ONE)) ? W_ONE : div_quo[WT_W-1:0];
            end
            st_q <= S_LDONE;
          end
        end
        S_LDONE: begin
          if (!ax_q) begin
            ix_q <= idx_q;
            ux_q <= wt_q;
            ax_q <= 1'b1;
            st_q <= S_LOC;
          end else begin
            iy_q  <= idx_q;
            uy_q  <= wt_q;
            cnt_q <= '0;
            st_q  <= S_GRID;
          end
        end
        // Fetch the four cell corners.
        S_GRID: begin
          if (cnt_q != 3'd0) begin
            z_q[cm1[1:0]] <= gr_rdata_q;
          end
          if (cnt_q == 3'd4) begin
            cnt_q <= '0;
            st_q  <= S_BLEND;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        // Blend both rows along y, then the row values along x.
        S_BLEND: begin
          unique case (cnt_q)
            3'd0: acc_q <= ACC_W'(prod);
            3'd1: acc_q <= acc_q + ACC_W'(prod);
            3'd2: begin
              a_q   <= rnd;
              acc_q <= ACC_W'(prod);
            end
            3'd3: acc_q <= acc_q + ACC_W'(prod);
            3'd4: begin
              b_q   <= rnd;
              acc_q <= ACC_W'(prod);
            end
            3'd5: acc_q <= acc_q + ACC_W'(prod);
            default: begin
              res_q <= rnd;
              st_q  <= S_FIN;
            end
          endcase
          cnt_q <= cnt_q + 3'd1;
        end
        // Hand the result to the output register once it is free.
        S_FIN: begin
          if (!ovalid_q || out_o.ready) begin
            ovalid_q <= 1'b1;
            ores_q   <= res_q;
            oout_q   <= outside_q;
            st_q     <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.result_value = ores_q;
  assign out_o.was_outside  = oout_q;

endmodule

>>> design/gbi_div.sv
// ----------------------------------------------------------------------------
// Unsigned restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module gbi_div #(
  parameter int unsigned DW = 55,
  parameter int unsigned VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  output logic [DW-1:0] quo_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] den_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   shl;
  logic [VW:0]   diff;
  logic          ge;

  // One trial subtraction of the shifted partial remainder.
  assign shl  = {rem_q, quo_q[DW-1]};
  assign diff = shl - {1'b0, den_q};
  assign ge   = (shl >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= ge ? diff[VW-1:0] : shl[VW-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule
